FILE: src/slcf_pkg.sv
// shared constants and types for the set-associative lru cache filter
package slcf_pkg;

  // width of the incoming byte address
  localparam int unsigned ADDR_W = 48;

  // per-access outcome flags passed from the way logic to the result stage
  typedef struct packed {
    logic hit;
    logic evict;
  } slcf_flags_t;

endpackage

FILE: src/slcf_ways.sv
// per-set lookup, lru age update and victim selection over all ways of one set
module slcf_ways #(
  parameter int unsigned WAYS = 2,
  parameter int unsigned AW   = 1,
  parameter int unsigned LW   = 42
) (
  input  logic [WAYS-1:0]    valid_i,
  input  logic [WAYS*AW-1:0] age_i,
  input  logic [WAYS*LW-1:0] line_i,
  input  logic [LW-1:0]      req_line_i,
  output logic [WAYS-1:0]    valid_o,
  output logic [WAYS*AW-1:0] age_o,
  output logic [WAYS*LW-1:0] line_o,
  output slcf_pkg::slcf_flags_t flags_o,
  output logic [LW-1:0]      evicted_line_o
);

  localparam logic [AW-1:0] AgeOldest = AW'(WAYS - 1);

  logic [WAYS-1:0] match;
  logic [WAYS-1:0] hit_oh;
  logic [WAYS-1:0] free_oh;
  logic [WAYS-1:0] victim_oh;
  logic [WAYS-1:0] chosen_oh;
  logic [AW-1:0]   hit_age;
  logic [LW-1:0]   victim_line;
  logic            is_hit;
  logic            is_full;

  // lowest matching way wins, lowest free way is filled first
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = valid_i[w] && (line_i[w*LW +: LW] == req_line_i);
    end
    hit_oh  = match & (~match + WAYS'(1));
    free_oh = ~valid_i & (valid_i + WAYS'(1));
    is_hit  = |match;
    is_full = &valid_i;
  end

  // highest-numbered oldest valid way is the victim, way 0 if none is oldest
  always_comb begin
    victim_oh = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (valid_i[w] && (age_i[w*AW +: AW] >= AgeOldest)) begin
        victim_oh    = '0;
        victim_oh[w] = 1'b1;
      end
    end
    if (victim_oh == '0) begin
      victim_oh[0] = 1'b1;
    end
  end

  always_comb begin
    chosen_oh   = is_full ? victim_oh : free_oh;
    hit_age     = '0;
    victim_line = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (hit_oh[w]) begin
        hit_age = hit_age | age_i[w*AW +: AW];
      end
      if (chosen_oh[w]) begin
        victim_line = victim_line | line_i[w*LW +: LW];
      end
    end
  end

  // new row contents
  always_comb begin
    valid_o = valid_i;
    age_o   = age_i;
    line_o  = line_i;
    for (int w = 0; w < WAYS; w++) begin
      if (is_hit) begin
        if (hit_oh[w]) begin
          age_o[w*AW +: AW] = '0;
        end else if (valid_i[w] && (age_i[w*AW +: AW] < hit_age)) begin
          age_o[w*AW +: AW] = age_i[w*AW +: AW] + AW'(1);
        end
      end else begin
        if (chosen_oh[w]) begin
          valid_o[w]        = 1'b1;
          age_o[w*AW +: AW] = '0;
          line_o[w*LW +: LW] = req_line_i;
        end else if (valid_i[w] && (age_i[w*AW +: AW] < AgeOldest)) begin
          age_o[w*AW +: AW] = age_i[w*AW +: AW] + AW'(1);
        end
      end
    end
  end

  always_comb begin
    flags_o.hit    = is_hit;
    flags_o.evict  = !is_hit && is_full;
    evicted_line_o = flags_o.evict ? victim_line : '0;
  end

endmodule

FILE: src/set_assoc_lru_cache_filter.sv
// top level of the set-associative lru cache filter: tag store, forwarding and result stage
//
// usage
//   an access beat is taken on a rising edge where start_i is high and busy_o is low;
//   byte_address_i carries the 48-bit byte address. one result beat follows per access,
//   shown for exactly one cycle with valid_o high: hit_o, set_index_o, line_address_o,
//   evict_valid_o and evicted_line_o. the receiver cannot stall, so results never wait.
// pipeline and throughput
//   an accepted access is registered in the access stage and its result in the output
//   registers; one access can be taken every cycle while busy_o is low. the set row
//   memory has one read port and one write port: one read at accept, one write back in
//   the next cycle, the just written row forwarded to a following access to that set
// reset
//   after rst_ni is released the block sweeps the tag store, one set per cycle, while
//   busy_o stays high; no access is taken during the sweep
// SETS must be a power of two; the set is the low bits of the line address
module set_assoc_lru_cache_filter #(
  parameter int unsigned SETS      = 2,
  parameter int unsigned WAYS      = 2,
  parameter int unsigned LINE_BITS = 6
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start_i,
  output logic                                      busy_o,
  input  logic [slcf_pkg::ADDR_W-1:0]               byte_address_i,
  output logic                                      valid_o,
  output logic                                      hit_o,
  output logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] set_index_o,
  output logic [slcf_pkg::ADDR_W-LINE_BITS-1:0]     line_address_o,
  output logic                                      evict_valid_o,
  output logic [slcf_pkg::ADDR_W-LINE_BITS-1:0]     evicted_line_o
);

  localparam int unsigned LW = slcf_pkg::ADDR_W - LINE_BITS;
  localparam int unsigned AW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned SW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned RW = WAYS * (1 + AW + LW);
  localparam logic [SW-1:0] LastSet = SW'(SETS - 1);

  // row layout: {lines, ages, valid bits}
  logic [RW-1:0] row_mem [SETS];

  logic          clr_q;
  logic [SW-1:0] clr_cnt_q;
  logic          accept;

  logic [LW-1:0] req_line;
  logic [SW-1:0] req_set;

  // access stage registers and the set taken from the registered line
  logic          s1_valid_q;
  logic [LW-1:0] s1_line_q;
  logic [RW-1:0] rd_row_q;
  logic [SW-1:0] s1_set;

  // forwarding of the most recent write back
  logic          fwd_valid_q;
  logic [SW-1:0] fwd_set_q;
  logic [RW-1:0] fwd_row_q;

  logic [RW-1:0] cur_row;
  logic [RW-1:0] new_row;

  logic [WAYS-1:0]    new_valid;
  logic [WAYS*AW-1:0] new_age;
  logic [WAYS*LW-1:0] new_line;
  slcf_pkg::slcf_flags_t flags;
  logic [LW-1:0]      victim_line;

  logic          mem_we;
  logic [SW-1:0] mem_wa;
  logic [RW-1:0] mem_wd;

  assign busy_o   = clr_q;
  assign accept   = start_i && !clr_q;
  assign req_line = byte_address_i[slcf_pkg::ADDR_W-1:LINE_BITS];
  assign req_set  = (SETS > 1) ? req_line[SW-1:0] : '0;
  assign s1_set   = (SETS > 1) ? s1_line_q[SW-1:0] : '0;

  // the latest write to this set may not yet be visible in the read data
  assign cur_row = (fwd_valid_q && (fwd_set_q == s1_set)) ? fwd_row_q : rd_row_q;

  slcf_ways #(
    .WAYS (WAYS),
    .AW   (AW),
    .LW   (LW)
  ) u_ways (
    .valid_i        (cur_row[WAYS-1:0]),
    .age_i          (cur_row[WAYS +: WAYS*AW]),
    .line_i         (cur_row[WAYS*(1+AW) +: WAYS*LW]),
    .req_line_i     (s1_line_q),
    .valid_o        (new_valid),
    .age_o          (new_age),
    .line_o         (new_line),
    .flags_o        (flags),
    .evicted_line_o (victim_line)
  );

  assign new_row = {new_line, new_age, new_valid};

  // write port: clearing sweep after reset, otherwise the updated row
  always_comb begin
    if (clr_q) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_q;
      mem_wd = '0;
    end else begin
      mem_we = s1_valid_q;
      mem_wa = s1_set;
      mem_wd = new_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      row_mem[mem_wa] <= mem_wd;
    end
    rd_row_q <= row_mem[req_set];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= 1'b1;
      clr_cnt_q   <= '0;
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      valid_o     <= 1'b0;
    end else begin
      if (clr_q) begin
        if (clr_cnt_q == LastSet) begin
          clr_q <= 1'b0;
        end
        clr_cnt_q <= clr_cnt_q + SW'(1);
      end
      s1_valid_q <= accept;
      if (s1_valid_q) begin
        fwd_valid_q <= 1'b1;
      end
      valid_o <= s1_valid_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_line_q <= req_line;
    end
    if (s1_valid_q) begin
      fwd_set_q      <= s1_set;
      fwd_row_q      <= new_row;
      hit_o          <= flags.hit;
      set_index_o    <= s1_set;
      line_address_o <= s1_line_q;
      evict_valid_o  <= flags.evict;
      evicted_line_o <= victim_line;
    end
  end

endmodule

FILE: tb/sv/tb_set_assoc_lru_cache_filter.sv
// self-checking testbench for the set-associative lru cache filter
module tb_set_assoc_lru_cache_filter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ADDR_W = slcf_pkg::ADDR_W;

  // block configuration, kept at the design defaults
  localparam int unsigned SETS      = 2;
  localparam int unsigned WAYS      = 2;
  localparam int unsigned LINE_BITS = 6;
  localparam int unsigned SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned LINE_W    = ADDR_W - LINE_BITS;
  localparam int unsigned ENTRIES   = SETS * WAYS;

  // run control: drain covers the result latency with margin,
  // the cycle cap is far above the slowest legal run (reset sweep included)
  localparam int unsigned DRAIN_CYC  = 8;
  localparam int unsigned CYCLE_CAP  = 200000;
  localparam int unsigned PHASE_BEATS = 310;
  localparam int unsigned POOL_SIZE  = 5;

  // one expected result beat
  typedef struct packed {
    logic              hit;
    logic [SET_W-1:0]  set_idx;
    logic [LINE_W-1:0] line;
    logic              evict;
    logic [LINE_W-1:0] victim_line;
  } access_res_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic [ADDR_W-1:0]     byte_address_i = '0;
  logic                  busy_o;
  logic                  valid_o;
  logic                  hit_o;
  logic [SET_W-1:0]      set_index_o;
  logic [LINE_W-1:0]     line_address_o;
  logic                  evict_valid_o;
  logic [LINE_W-1:0]     evicted_line_o;

  // accesses waiting to be driven, and outcomes waiting to be seen
  logic [ADDR_W-1:0] access_q[$];
  access_res_t       outcome_q[$];

  // shadow tag store, indexed set*WAYS + way
  logic              tag_valid[ENTRIES];
  logic [LINE_W-1:0] tag_line[ENTRIES];
  int                tag_rank[ENTRIES];

  int unsigned idle_pct = 0;
  int unsigned cycle_cnt = 0;
  int unsigned n_fail = 0;

  set_assoc_lru_cache_filter #(
    .SETS      (SETS),
    .WAYS      (WAYS),
    .LINE_BITS (LINE_BITS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .byte_address_i (byte_address_i),
    .valid_o        (valid_o),
    .hit_o          (hit_o),
    .set_index_o    (set_index_o),
    .line_address_o (line_address_o),
    .evict_valid_o  (evict_valid_o),
    .evicted_line_o (evicted_line_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicts one access and updates the shadow tag store: true lru, rank 0 is
  // the most recent line, rank WAYS-1 the victim when the set is full
  function automatic access_res_t cache_access(input logic [ADDR_W-1:0] addr);
    access_res_t       res;
    logic [LINE_W-1:0] line;
    int                set_no;
    int                base;
    int                hit_way;
    int                free_way;
    int                victim;
    int                chosen;
    int                old_rank;
    res      = '0;
    line     = addr[ADDR_W-1:LINE_BITS];
    set_no   = int'(line % SETS);
    base     = set_no * WAYS;
    hit_way  = -1;
    free_way = -1;
    victim   = -1;
    for (int w = 0; w < WAYS; w++) begin
      if (tag_valid[base + w]) begin
        if (hit_way < 0 && tag_line[base + w] == line) hit_way = w;
        if (tag_rank[base + w] >= WAYS - 1) victim = w;
      end else if (free_way < 0) begin
        free_way = w;
      end
    end
    if (hit_way >= 0) begin
      // lines more recent than the hit line age by one
      old_rank = tag_rank[base + hit_way];
      for (int w = 0; w < WAYS; w++) begin
        if (tag_valid[base + w] && tag_rank[base + w] < old_rank)
          tag_rank[base + w]++;
      end
      tag_rank[base + hit_way] = 0;
      res.hit = 1'b1;
    end else begin
      if (free_way >= 0) begin
        chosen = free_way;
      end else begin
        // full set: the oldest line goes
        chosen = (victim >= 0) ? victim : 0;
        res.evict       = 1'b1;
        res.victim_line = tag_line[base + chosen];
      end
      for (int w = 0; w < WAYS; w++) begin
        if (w != chosen && tag_valid[base + w] && tag_rank[base + w] < WAYS - 1)
          tag_rank[base + w]++;
      end
      tag_valid[base + chosen] = 1'b1;
      tag_line[base + chosen]  = line;
      tag_rank[base + chosen]  = 0;
    end
    res.set_idx = SET_W'(set_no);
    res.line    = line;
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] mk_addr(input logic [LINE_W-1:0] line,
                                                input logic [LINE_BITS-1:0] off);
    return {line, off};
  endfunction

  // appends one access to the pending queue
  function automatic void add_access(input logic [ADDR_W-1:0] addr);
    access_q = {access_q, addr};
  endfunction

  // driver: predicts each accepted beat, then offers the next one unless the
  // current phase decides to leave a gap; a beat held off by busy stays put
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) outcome_q = {outcome_q, cache_access(byte_address_i)};
      if (!start_i || !busy_o) begin
        if (access_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          start_i        <= 1'b1;
          byte_address_i <= access_q.pop_front();
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor: every valid beat is matched against the oldest outcome
  always @(posedge clk_i) begin
    access_res_t exp_res;
    if (rst_ni && valid_o) begin
      if (outcome_q.size() == 0) begin
        $error("result beat with no access outstanding: line_address_o %0h", line_address_o);
        n_fail++;
      end else begin
        exp_res = outcome_q.pop_front();
        if (hit_o !== exp_res.hit) begin
          $error("hit_o: expected %0h, got %0h", exp_res.hit, hit_o);
          n_fail++;
        end
        if (set_index_o !== exp_res.set_idx) begin
          $error("set_index_o: expected %0h, got %0h", exp_res.set_idx, set_index_o);
          n_fail++;
        end
        if (line_address_o !== exp_res.line) begin
          $error("line_address_o: expected %0h, got %0h", exp_res.line, line_address_o);
          n_fail++;
        end
        if (evict_valid_o !== exp_res.evict) begin
          $error("evict_valid_o: expected %0h, got %0h", exp_res.evict, evict_valid_o);
          n_fail++;
        end
        if (evicted_line_o !== exp_res.victim_line) begin
          $error("evicted_line_o: expected %0h, got %0h", exp_res.victim_line,
                 evicted_line_o);
          n_fail++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // waits at the falling edge until every queued access has been taken and answered
  task automatic wait_drained();
    do @(negedge clk_i);
    while (access_q.size() != 0 || start_i || outcome_q.size() != 0);
  endtask

  // random accesses: mostly reuse of a small line pool so sets fill, hit and
  // evict; the rest are arbitrary 48-bit addresses as noise
  task automatic queue_random(input int unsigned beats);
    logic [LINE_W-1:0] pool[POOL_SIZE];
    for (int unsigned i = 0; i < beats; i++) begin
      if (i % 40 == 0) begin
        foreach (pool[p]) pool[p] = LINE_W'({$urandom(), $urandom()});
      end
      if ($urandom_range(99) < 85)
        add_access(mk_addr(pool[$urandom_range(POOL_SIZE - 1)],
                           LINE_BITS'($urandom())));
      else
        add_access(ADDR_W'({$urandom(), $urandom()}));
    end
  endtask

  initial begin
    // sender idle percentage per phase; the receiver cannot stall
    int unsigned phase_idle[4];
    phase_idle = '{0, 78, 0, 9};
    foreach (tag_valid[e]) begin
      tag_valid[e] = 1'b0;
      tag_line[e]  = '0;
      tag_rank[e]  = 0;
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part, set 0 then set 1, then patterned addresses over both sets
    add_access(mk_addr(LINE_W'(0), '0));          // miss into an empty set
    add_access(mk_addr(LINE_W'(0), '1));          // same line, top offset: hit
    add_access(mk_addr(LINE_W'(2), LINE_BITS'(21))); // fills the free way
    add_access(mk_addr(LINE_W'(0), '0));          // hit, line 2 becomes oldest
    add_access(mk_addr(LINE_W'(4), '0));          // full set, evicts line 2
    add_access(mk_addr(LINE_W'(2), '0));          // full set, evicts line 0
    add_access(mk_addr(LINE_W'(4), '1));          // hit on the newest-but-one
    add_access({ADDR_W{1'b1}});                   // all-ones address into set 1
    add_access(mk_addr('1, '0));                  // hit on the all-ones line
    add_access(mk_addr(LINE_W'(1), '0));          // second way of set 1
    add_access(mk_addr(LINE_W'(3), '0));          // evicts the all-ones line
    add_access(mk_addr(LINE_W'(1), '1));
    add_access(mk_addr(LINE_W'(3), '1));
    add_access(48'hAAAA_AAAA_AAAA);
    add_access(48'h5555_5555_5555);
    add_access(48'h8000_0000_0000);               // top bit alone
    add_access(48'h0000_0000_0040);               // lowest line bit alone
    add_access(48'hAAAA_AAAA_AAAA);
    wait_drained();

    // random part in phases of differing sender gaps
    foreach (phase_idle[ph]) begin
      idle_pct = phase_idle[ph];
      queue_random(PHASE_BEATS);
      wait_drained();
    end

    repeat (DRAIN_CYC) @(posedge clk_i);
    if (n_fail == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
